// ===== rtl/qte_pkg.sv =====
// Shared constants, arctangent table and angle rounding for the quaternion to Euler block.
// No dependencies; every other file in rtl/ imports this package.
package qte_pkg;

	localparam int DEF_COMPONENT_BITS = 16;
	localparam int DEF_CORDIC_STAGES  = 16;
	localparam int ATAN_ENTRIES       = 24;

	localparam int Q_BITS    = 16; // components after alignment to Q1.14
	localparam int P_BITS    = 32; // one product, Q2.28
	localparam int V_BITS    = 34; // CORDIC input vector component
	localparam int S_BITS    = 30; // clamped asin argument, Q2.28
	localparam int SQ_BITS   = 57; // 1 - s^2 in Q4.56
	localparam int ROOT_BITS = 29; // isqrt result
	localparam int SQRT_STEPS = 29;
	localparam int Z_BITS    = 35; // angle accumulator, Q30, with room to negate
	localparam int CW        = 53; // CORDIC x/y datapath
	localparam int ANGLE_BITS = 16;
	localparam int YAW_BITS   = 15;

	localparam logic signed [Z_BITS-1:0] PI_Q30    = 35'sd3373259426;
	localparam logic signed [ANGLE_BITS-1:0] PITCH_LIMIT = 16'sd25736;
	localparam logic signed [ANGLE_BITS-1:0] YAW_LIMIT   = 16'sd12868;
	localparam logic signed [S_BITS-1:0] UNIT_Q28 = 30'sd268435456;

	function automatic logic signed [Z_BITS-1:0] atan_q30(input int idx);
		logic signed [Z_BITS-1:0] a;
		case (idx)
			0:  a = 35'sd843314857;
			1:  a = 35'sd497837829;
			2:  a = 35'sd263043837;
			3:  a = 35'sd133525159;
			4:  a = 35'sd67021687;
			5:  a = 35'sd33543516;
			6:  a = 35'sd16775851;
			7:  a = 35'sd8388437;
			8:  a = 35'sd4194283;
			9:  a = 35'sd2097149;
			10: a = 35'sd1048576;
			11: a = 35'sd524288;
			12: a = 35'sd262144;
			13: a = 35'sd131072;
			14: a = 35'sd65536;
			15: a = 35'sd32768;
			16: a = 35'sd16384;
			17: a = 35'sd8192;
			18: a = 35'sd4096;
			19: a = 35'sd2048;
			20: a = 35'sd1024;
			21: a = 35'sd512;
			22: a = 35'sd256;
			23: a = 35'sd128;
			default: a = '0;
		endcase
		return a;
	endfunction

	// Q30 radians to Q3.13, round half up, then clamp to +/- lim.
	function automatic logic signed [ANGLE_BITS-1:0] to_q13(
		input logic signed [Z_BITS-1:0] z,
		input logic signed [ANGLE_BITS-1:0] lim
	);
		logic signed [Z_BITS:0] t;
		logic signed [19:0] a;
		logic signed [19:0] l;
		t = (Z_BITS+1)'(z) + 36'sd65536;
		a = 20'(t >>> 17);
		l = 20'(lim);
		if (a > l)
			a = l;
		if (a < -l)
			a = -l;
		return ANGLE_BITS'(a);
	endfunction

endpackage

// ===== rtl/qte_quat_if.sv =====
// Input channel: one orientation quaternion per beat, valid/ready handshake.
// Depends on qte_pkg.
interface qte_quat_if
	import qte_pkg::*;
#(
	parameter int COMPONENT_BITS = DEF_COMPONENT_BITS
);
	logic valid;
	logic ready;
	logic signed [COMPONENT_BITS-1:0] quat_w;
	logic signed [COMPONENT_BITS-1:0] quat_x;
	logic signed [COMPONENT_BITS-1:0] quat_y;
	logic signed [COMPONENT_BITS-1:0] quat_z;

	modport source(output valid, quat_w, quat_x, quat_y, quat_z, input ready);
	modport sink(input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

// ===== rtl/qte_euler_if.sv =====
// Output channel: pitch, roll and yaw in Q3.13 radians per beat, valid/ready handshake.
// Depends on qte_pkg.
interface qte_euler_if
	import qte_pkg::*;
;
	logic valid;
	logic ready;
	logic signed [ANGLE_BITS-1:0] pitch_angle;
	logic signed [ANGLE_BITS-1:0] roll_angle;
	logic signed [YAW_BITS-1:0]   yaw_angle;

	modport source(output valid, pitch_angle, roll_angle, yaw_angle, input ready);
	modport sink(input valid, pitch_angle, roll_angle, yaw_angle, output ready);
endinterface

// ===== rtl/qte_isqrt.sv =====
// Pipelined digit-by-digit integer square root, one result bit per stage,
// with a side payload delayed alongside. Depends on qte_pkg.
module qte_isqrt
	import qte_pkg::*;
#(
	parameter int SIDE_BITS = 1
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [SQ_BITS-1:0]   rad,
	input  logic [SIDE_BITS-1:0] side_in,
	output logic [ROOT_BITS-1:0] root,
	output logic [SIDE_BITS-1:0] side_out
);
	localparam int RW = SQ_BITS + 1;

	logic [SQ_BITS-1:0]   rem_s  [SQRT_STEPS+1];
	logic [RW-1:0]        res_s  [SQRT_STEPS+1];
	logic [SIDE_BITS-1:0] side_s [SQRT_STEPS+1];

	assign rem_s[0]  = rad;
	assign res_s[0]  = '0;
	assign side_s[0] = side_in;

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (SQRT_STEPS - 1 - k));
		logic [RW-1:0] trial;
		logic          take;
		assign trial = res_s[k] + BIT;
		assign take  = RW'(rem_s[k]) >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				if (take) begin
					rem_s[k+1] <= rem_s[k] - SQ_BITS'(trial);
					res_s[k+1] <= (res_s[k] >> 1) + BIT;
				end else begin
					rem_s[k+1] <= rem_s[k];
					res_s[k+1] <= res_s[k] >> 1;
				end
				side_s[k+1] <= side_s[k];
			end
		end
	end

	assign root     = ROOT_BITS'(res_s[SQRT_STEPS]);
	assign side_out = side_s[SQRT_STEPS];
endmodule

// ===== rtl/qte_cordic.sv =====
// Pipelined vectoring CORDIC: atan2(y, x) in Q30 radians, one rotation per stage.
// Depends on qte_pkg.
module qte_cordic
	import qte_pkg::*;
#(
	parameter int STAGES = DEF_CORDIC_STAGES
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic signed [V_BITS-1:0] vec_y,
	input  logic signed [V_BITS-1:0] vec_x,
	output logic signed [Z_BITS-1:0] angle
);
	logic signed [CW-1:0]     x_s [STAGES+1];
	logic signed [CW-1:0]     y_s [STAGES+1];
	logic signed [Z_BITS-1:0] z_s [STAGES+1];
	logic                     zero_s [STAGES+1];

	logic signed [CW-1:0] xin, yin;
	assign xin = CW'(vec_x) <<< 16;
	assign yin = CW'(vec_y) <<< 16;

	// Fold the left half-plane over and start from +/- pi.
	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (vec_x == '0) && (vec_y == '0);
			if (vec_x < 0) begin
				x_s[0] <= -xin;
				y_s[0] <= -yin;
				z_s[0] <= (vec_y >= 0) ? PI_Q30 : -PI_Q30;
			end else begin
				x_s[0] <= xin;
				y_s[0] <= yin;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_rot
		localparam logic signed [Z_BITS-1:0] ATAN = atan_q30(i);
		logic signed [CW-1:0] xsh, ysh;
		assign xsh = x_s[i] >>> i;
		assign ysh = y_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i] > 0) begin
					x_s[i+1] <= x_s[i] + ysh;
					y_s[i+1] <= y_s[i] - xsh;
					z_s[i+1] <= z_s[i] + ATAN;
				end else begin
					x_s[i+1] <= x_s[i] - ysh;
					y_s[i+1] <= y_s[i] + xsh;
					z_s[i+1] <= z_s[i] - ATAN;
				end
			end
		end
	end

	assign angle = zero_s[STAGES] ? '0 : z_s[STAGES];
endmodule

// ===== rtl/quaternion_to_euler_angles.sv =====
// Top level: quaternion to pitch/roll/yaw, fully pipelined.
// Depends on qte_pkg, qte_quat_if, qte_euler_if, qte_isqrt, qte_cordic.
//
//   channel   dir  payload                                  handshake
//   quat      in   quat_w, quat_x, quat_y, quat_z (Q1.14)   valid/ready
//   angles    out  pitch_angle, roll_angle, yaw_angle (Q3.13) valid/ready
//
// One beat enters per cycle unless the output beat is held. The stages are
// products, sums, s^2, 29 square-root steps, CORDIC fold, CORDIC_STAGES
// rotations with the rotation count capped at 24, and rounding. The
// square-root chain sets the largest part of that depth.
// Reset clears only the valid bits. When the output beat is held, every
// stage freezes together, so nothing is dropped or repeated.
module quaternion_to_euler_angles
	import qte_pkg::*;
#(
	parameter int COMPONENT_BITS = DEF_COMPONENT_BITS,
	parameter int CORDIC_STAGES  = DEF_CORDIC_STAGES
) (
	input logic          clk,
	input logic          arst_n,
	qte_quat_if.sink     quat,
	qte_euler_if.source  angles
);
	localparam int NSTG = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
	localparam int LAT  = 3 + SQRT_STEPS + 1 + NSTG + 1;
	localparam int SIDE_BITS = 4 * V_BITS + S_BITS;

	logic [LAT-1:0] vld_q;
	logic           adv;

	// Advance the whole pipe unless the output beat is held.
	assign adv        = !vld_q[LAT-1] || angles.ready;
	assign quat.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], quat.valid};
		end
	end

	// Align components to Q1.14: floor right for wide inputs, pad narrow ones.
	logic signed [COMPONENT_BITS-1:0] raw [4];
	logic signed [Q_BITS-1:0]         q   [4];
	assign raw[0] = quat.quat_w;
	assign raw[1] = quat.quat_x;
	assign raw[2] = quat.quat_y;
	assign raw[3] = quat.quat_z;

	for (genvar c = 0; c < 4; c++) begin : g_align
		if (COMPONENT_BITS >= Q_BITS) begin : g_dn
			assign q[c] = Q_BITS'(raw[c] >>> (COMPONENT_BITS - Q_BITS));
		end else begin : g_up
			assign q[c] = {raw[c], {(Q_BITS - COMPONENT_BITS){1'b0}}};
		end
	end

	// Stage 1: the ten products.
	logic signed [P_BITS-1:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1;
	logic signed [P_BITS-1:0] wz_s1, wx_s1, yz_s1, xz_s1, wy_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ww_s1 <= q[0] * q[0];
			xx_s1 <= q[1] * q[1];
			yy_s1 <= q[2] * q[2];
			zz_s1 <= q[3] * q[3];
			xy_s1 <= q[1] * q[2];
			wz_s1 <= q[0] * q[3];
			wx_s1 <= q[0] * q[1];
			yz_s1 <= q[2] * q[3];
			xz_s1 <= q[1] * q[3];
			wy_s1 <= q[0] * q[2];
		end
	end

	// Stage 2: the five sums; clamp the asin argument to [-1, 1].
	logic signed [V_BITS-1:0] py_s2, px_s2, ry_s2, rx_s2;
	logic signed [S_BITS-1:0] s_s2;
	logic signed [V_BITS-1:0] s_raw;

	assign s_raw = (V_BITS'(xz_s1) - V_BITS'(wy_s1)) <<< 1;

	always_ff @(posedge clk) begin
		if (adv) begin
			py_s2 <= (V_BITS'(xy_s1) + V_BITS'(wz_s1)) <<< 1;
			px_s2 <= V_BITS'(ww_s1) + V_BITS'(xx_s1) - V_BITS'(yy_s1) - V_BITS'(zz_s1);
			ry_s2 <= (V_BITS'(wx_s1) + V_BITS'(yz_s1)) <<< 1;
			rx_s2 <= V_BITS'(ww_s1) - V_BITS'(xx_s1) - V_BITS'(yy_s1) + V_BITS'(zz_s1);
			if (s_raw > V_BITS'(UNIT_Q28))
				s_s2 <= UNIT_Q28;
			else if (s_raw < -V_BITS'(UNIT_Q28))
				s_s2 <= -UNIT_Q28;
			else
				s_s2 <= S_BITS'(s_raw);
		end
	end

	// Stage 3: radicand 1 - s^2 in Q4.56.
	localparam logic [2*S_BITS-1:0] UNIT_SQ = (2*S_BITS)'(1) << 56;
	logic signed [2*S_BITS-1:0] s_sq;
	logic [SQ_BITS-1:0]         rad_s3;
	logic [SIDE_BITS-1:0]       side_s3;

	assign s_sq = s_s2 * s_s2;

	always_ff @(posedge clk) begin
		if (adv) begin
			rad_s3  <= SQ_BITS'(UNIT_SQ - unsigned'(s_sq));
			side_s3 <= {py_s2, px_s2, ry_s2, rx_s2, s_s2};
		end
	end

	// Square-root chain: cos(yaw) magnitude, with the other operands riding along.
	logic [ROOT_BITS-1:0] root;
	logic [SIDE_BITS-1:0] side_rt;

	qte_isqrt #(
		.SIDE_BITS(SIDE_BITS)
	) u_isqrt (
		.clk     (clk),
		.en      (adv),
		.rad     (rad_s3),
		.side_in (side_s3),
		.root    (root),
		.side_out(side_rt)
	);

	logic signed [V_BITS-1:0] py_rt, px_rt, ry_rt, rx_rt;
	logic signed [S_BITS-1:0] s_rt;
	assign {py_rt, px_rt, ry_rt, rx_rt, s_rt} = side_rt;

	// Three CORDIC lanes in lock step.
	logic signed [Z_BITS-1:0] pitch_z, roll_z, yaw_z;

	qte_cordic #(.STAGES(NSTG)) u_pitch (
		.clk(clk), .en(adv), .vec_y(py_rt), .vec_x(px_rt), .angle(pitch_z)
	);

	qte_cordic #(.STAGES(NSTG)) u_roll (
		.clk(clk), .en(adv), .vec_y(ry_rt), .vec_x(rx_rt), .angle(roll_z)
	);

	qte_cordic #(.STAGES(NSTG)) u_yaw (
		.clk  (clk),
		.en   (adv),
		.vec_y(V_BITS'(s_rt)),
		.vec_x(V_BITS'({1'b0, root})),
		.angle(yaw_z)
	);

	// Output register: round to Q3.13 and saturate; yaw takes the negated angle.
	logic signed [ANGLE_BITS-1:0] pitch_q, roll_q, yaw_full;
	logic signed [YAW_BITS-1:0]   yaw_q;

	assign yaw_full = to_q13(-yaw_z, YAW_LIMIT);

	always_ff @(posedge clk) begin
		if (adv) begin
			pitch_q <= to_q13(pitch_z, PITCH_LIMIT);
			roll_q  <= to_q13(roll_z, PITCH_LIMIT);
			yaw_q   <= YAW_BITS'(yaw_full);
		end
	end

	assign angles.valid       = vld_q[LAT-1];
	assign angles.pitch_angle = pitch_q;
	assign angles.roll_angle  = roll_q;
	assign angles.yaw_angle   = yaw_q;

`ifndef SYNTHESIS
	// A held output beat blocks new input.
	a_stall_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		angles.valid && !angles.ready |-> !quat.ready)
		else $error("input accepted while output beat held");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		angles.valid |-> (angles.yaw_angle <= 15'sd12868) && (angles.yaw_angle >= -15'sd12868))
		else $error("yaw out of range");

	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		angles.valid |-> (angles.pitch_angle <= PITCH_LIMIT) && (angles.pitch_angle >= -PITCH_LIMIT)
			&& (angles.roll_angle <= PITCH_LIMIT) && (angles.roll_angle >= -PITCH_LIMIT))
		else $error("pitch or roll out of range");
`endif

endmodule

// ===== tb/sv/tb_quaternion_to_euler_angles.sv =====
// Testbench for quaternion_to_euler_angles: random and directed quaternions with bursty
// input, stalled output, and a scoreboard fed by an independent fixed-point predictor.
// Depends on qte_pkg, qte_quat_if, qte_euler_if and the RTL top level.
`timescale 1ns / 1ps

module tb_quaternion_to_euler_angles;
	import qte_pkg::*;

	localparam int LATENCY = 35 + DEF_CORDIC_STAGES;

	typedef struct packed {
		logic signed [15:0] w;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
	} quat_t;

	typedef struct packed {
		logic signed [ANGLE_BITS-1:0] pitch;
		logic signed [ANGLE_BITS-1:0] roll;
		logic signed [YAW_BITS-1:0]   yaw;
	} euler_t;

	// Arctangent table, atan(2^-i) in Q30, for the predictor's own use.
	localparam longint ATAN_TBL [16] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288,
		262144, 131072, 65536, 32768};
	localparam longint PI_FIX = 64'sd3373259426;
	localparam longint ONE_Q28 = 64'sd268435456;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	qte_quat_if  quat ();
	qte_euler_if angles ();

	quaternion_to_euler_angles u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.quat   (quat.sink),
		.angles (angles.source)
	);

	always #5 clk = ~clk;

	quat_t  pending_quats [$];
	euler_t expected_angles [$];
	int     errors = 0;
	bit     stim_done = 1'b0;

	// Vectoring CORDIC in Q30; >>> on longint floors like the block does.
	function automatic longint cordic_angle(longint vy, longint vx);
		longint ang, xs, ys;
		ang = 0;
		if (vx == 0 && vy == 0)
			return 0;
		if (vx < 0) begin
			ang = (vy >= 0) ? PI_FIX : -PI_FIX;
			vx = -vx;
			vy = -vy;
		end
		vx = vx * 65536;
		vy = vy * 65536;
		for (int i = 0; i < DEF_CORDIC_STAGES; i++) begin
			xs = vx >>> i;
			ys = vy >>> i;
			if (vy > 0) begin
				vx += ys;
				vy -= xs;
				ang += ATAN_TBL[i];
			end else begin
				vx -= ys;
				vy += xs;
				ang -= ATAN_TBL[i];
			end
		end
		return ang;
	endfunction

	function automatic longint round_q13(longint ang, longint lim);
		longint a;
		a = (ang + 65536) >>> 17;
		if (a > lim) a = lim;
		if (a < -lim) a = -lim;
		return a;
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else
				r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	function automatic euler_t predict_angles(quat_t q);
		longint q0, q1, q2, q3, py, px, ry, rx, s, c;
		euler_t e;
		q0 = q.w; q1 = q.x; q2 = q.y; q3 = q.z;
		py = 2 * (q1 * q2 + q0 * q3);
		px = q0 * q0 + q1 * q1 - q2 * q2 - q3 * q3;
		ry = 2 * (q0 * q1 + q2 * q3);
		rx = q0 * q0 - q1 * q1 - q2 * q2 + q3 * q3;
		s = 2 * (q1 * q3 - q0 * q2);
		// clamp the arcsine argument so yaw saturates at +/- pi/2
		if (s > ONE_Q28) s = ONE_Q28;
		if (s < -ONE_Q28) s = -ONE_Q28;
		c = longint'(int_sqrt(longint'(ONE_Q28 * ONE_Q28 - s * s)));
		e.pitch = ANGLE_BITS'(round_q13(cordic_angle(py, px), 25736));
		e.roll  = ANGLE_BITS'(round_q13(cordic_angle(ry, rx), 25736));
		e.yaw   = YAW_BITS'(round_q13(-cordic_angle(s, c), 12868));
		return e;
	endfunction

	function automatic logic signed [15:0] rand_comp();
		case ($urandom_range(0, 5))
			0: return 16'(int'($urandom_range(0, 32768)) - 16384);
			1: return 16'($urandom); // beyond +/-1, every bit pattern
			2: return 16'(int'($urandom_range(0, 64)) - 32);
			default: return 16'(int'($urandom_range(0, 23170)) - 11585);
		endcase
	endfunction

	// Fill the item queue: directed corners first, then random quaternions.
	initial begin
		quat_t q;
		logic signed [15:0] corner [6];
		corner = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd32767, -16'sd32768, 16'sd11585};
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0});       // zero vector
		pending_quats.push_back('{16'sd16384, 16'sd0, 16'sd0, 16'sd0});   // identity
		pending_quats.push_back('{16'sd0, 16'sd16384, 16'sd0, 16'sd0});   // negative x, y=0
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd16384, 16'sd0});
		pending_quats.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd16384});
		pending_quats.push_back('{16'sd11585, 16'sd0, 16'sd11585, 16'sd0}); // yaw +pi/2
		pending_quats.push_back('{16'sd11585, 16'sd0, -16'sd11585, 16'sd0}); // yaw -pi/2
		pending_quats.push_back('{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384}); // non-unit quaternion
		pending_quats.push_back('{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767});
		pending_quats.push_back('{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767});
		pending_quats.push_back('{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768});
		pending_quats.push_back('{16'sd0, 16'sd1, -16'sd1, 16'sd0});       // pitch vector x=0, y<0
		pending_quats.push_back('{16'sd1, 16'sd0, 16'sd0, 16'sd1});
		for (int i = 0; i < 10; i++)
			pending_quats.push_back('{corner[$urandom_range(0, 5)], corner[$urandom_range(0, 5)],
				corner[$urandom_range(0, 5)], corner[$urandom_range(0, 5)]});
		for (int i = 0; i < 1000; i++) begin
			q.w = rand_comp(); q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp();
			pending_quats.push_back(q);
		end
		stim_done = 1'b1;
	end

	// Sender: bursts of random length separated by random gaps.
	int burst_left = 0;
	int gap_left = 0;
	bit in_taken = 1'b0;
	initial begin
		quat.valid = 1'b0;
		quat.quat_w = '0; quat.quat_x = '0; quat.quat_y = '0; quat.quat_z = '0;
	end

	// Note the input handshake at the rising edge where it happens.
	always @(posedge clk)
		in_taken = arst_n && quat.valid && quat.ready;

	always @(negedge clk) begin
		if (arst_n) begin
			// drop the beat that was accepted at the last rising edge
			if (in_taken)
				void'(pending_quats.pop_front());
			if (quat.valid && !in_taken) begin
				// hold the offered beat until it is accepted
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				quat.valid <= 1'b0;
			end else if (pending_quats.size() > 0) begin
				quat.valid  <= 1'b1;
				quat.quat_w <= pending_quats[0].w;
				quat.quat_x <= pending_quats[0].x;
				quat.quat_y <= pending_quats[0].y;
				quat.quat_z <= pending_quats[0].z;
				if (burst_left > 0)
					burst_left <= burst_left - 1;
				else begin
					burst_left <= $urandom_range(1, 40);
					gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
				end
			end else
				quat.valid <= 1'b0;
		end
	end

	// Receiver: stalls on its own pattern, with one long hold-off to fill the pipe.
	int accepted_out = 0;
	int hold_left = 0;
	int stall_mode = 0;
	initial angles.ready = 1'b0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (accepted_out == 200 && hold_left == 0 && stall_mode == 0) begin
				hold_left  <= 300;
				stall_mode <= 1;
				angles.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				angles.ready <= 1'b0;
			end else begin
				case ((accepted_out / 128) % 3)
					0: angles.ready <= 1'b1;
					1: angles.ready <= ($urandom_range(0, 3) != 0);
					default: angles.ready <= ($urandom_range(0, 2) == 0);
				endcase
			end
		end
	end

	// Monitor: predict on accepted inputs, compare accepted outputs.
	always @(posedge clk) begin
		euler_t exp_e;
		if (arst_n) begin
			if (quat.valid && quat.ready)
				expected_angles.push_back(predict_angles(
					'{quat.quat_w, quat.quat_x, quat.quat_y, quat.quat_z}));
			if (angles.valid && angles.ready) begin
				accepted_out <= accepted_out + 1;
				if (expected_angles.size() == 0) begin
					$error("angles beat with nothing expected");
					errors++;
				end else begin
					exp_e = expected_angles.pop_front();
					if (angles.pitch_angle !== exp_e.pitch) begin
						$error("pitch_angle expected %0d got %0d", exp_e.pitch, angles.pitch_angle);
						errors++;
					end
					if (angles.roll_angle !== exp_e.roll) begin
						$error("roll_angle expected %0d got %0d", exp_e.roll, angles.roll_angle);
						errors++;
					end
					if (angles.yaw_angle !== exp_e.yaw) begin
						$error("yaw_angle expected %0d got %0d", exp_e.yaw, angles.yaw_angle);
						errors++;
					end
				end
			end
		end
	end

	// Reset, then wait for stimulus to drain and the pipe to empty.
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (stim_done);
		while (pending_quats.size() > 0 || quat.valid || expected_angles.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_angles.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/qte_pkg.sv
rtl/qte_quat_if.sv
rtl/qte_euler_if.sv
rtl/qte_isqrt.sv
rtl/qte_cordic.sv
rtl/quaternion_to_euler_angles.sv
tb/sv/tb_quaternion_to_euler_angles.sv
